// ===== rtl/core/jsu_pkg.sv =====
// shared types and codes for the json string unescape block
package jsu_pkg;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_EXPECTED   = 4'd1;
    localparam logic [3:0] ERR_UNTERM     = 4'd2;
    localparam logic [3:0] ERR_CTRL       = 4'd3;
    localparam logic [3:0] ERR_UNTERM_ESC = 4'd4;
    localparam logic [3:0] ERR_BAD_ESC    = 4'd5;
    localparam logic [3:0] ERR_TRUNC_U    = 4'd6;
    localparam logic [3:0] ERR_BAD_U      = 4'd7;
    localparam logic [3:0] ERR_LONE_HIGH  = 4'd8;
    localparam logic [3:0] ERR_BAD_LOW    = 4'd9;
    localparam logic [3:0] ERR_LONE_LOW   = 4'd10;

    localparam int JOB_DEPTH = 4;
    localparam int JOB_AW    = $clog2(JOB_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [3:0] error_code;
        logic       run_last;
    } t_out_beat;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [3:0] err;
    } t_tail;

    // all results caused by one input byte: data bytes first, then an optional tail
    typedef struct packed {
        logic [2:0]      ndata;
        logic [3:0][7:0] bytes;
        t_tail           tail;
    } t_job;

endpackage

// ===== rtl/core/jsu_front.sv =====
// front end: parser state machine, turns each input beat into at most one job
module jsu_front
    import jsu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_beat i_beat,
    output logic     o_job_valid,
    output t_job     o_job
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [2:0] {
        IDLE, STR, ESC, HEX, WANT_BS, WANT_U
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_bad, n_bad;
    logic [9:0]  r_high, n_high;
    logic        r_low, n_low;

    logic [7:0]  c;
    logic        fin;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] acc_next;
    logic        esc_ok;
    logic [7:0]  esc_val;
    logic [20:0] cp;
    t_job        job;

    function automatic t_tail fail_tail(input logic [3:0] err);
        t_tail t;
        t.valid = 1'b1;
        t.kind  = KIND_ERROR;
        t.err   = err;
        return t;
    endfunction

    function automatic void utf8_encode(input logic [20:0] v, output logic [2:0] n,
                                        output logic [3:0][7:0] b);
        b = '0;
        if (v < 21'h80) begin
            n    = 3'd1;
            b[0] = v[7:0];
        end else if (v < 21'h800) begin
            n    = 3'd2;
            b[0] = {3'b110, v[10:6]};
            b[1] = {2'b10, v[5:0]};
        end else if (v < 21'h10000) begin
            n    = 3'd3;
            b[0] = {4'b1110, v[15:12]};
            b[1] = {2'b10, v[11:6]};
            b[2] = {2'b10, v[5:0]};
        end else begin
            n    = 3'd4;
            b[0] = {5'b11110, v[20:18]};
            b[1] = {2'b10, v[17:12]};
            b[2] = {2'b10, v[11:6]};
            b[3] = {2'b10, v[5:0]};
        end
    endfunction

    assign c   = i_beat.in_byte;
    assign fin = i_beat.final_byte;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        esc_ok  = 1'b1;
        esc_val = c;
        case (c)
            8'h22, 8'h5C, 8'h2F: esc_val = c;
            8'h62:               esc_val = 8'h08;
            8'h66:               esc_val = 8'h0C;
            8'h6E:               esc_val = 8'h0A;
            8'h72:               esc_val = 8'h0D;
            8'h74:               esc_val = 8'h09;
            default:             esc_ok  = 1'b0;
        endcase
    end

    assign acc_next = {r_acc[11:0], hex_val};

    always_comb begin
        if (r_low) begin
            cp = 21'h10000 + {1'b0, r_high, 10'd0} + {11'd0, acc_next[9:0]};
        end else begin
            cp = {5'd0, acc_next};
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_bad  = r_bad;
        n_high = r_high;
        n_low  = r_low;
        job    = '0;
        case (r_mode)
            STR: begin
                if (c == CH_QUOTE) begin
                    job.tail = '{valid: 1'b1, kind: KIND_DONE, err: ERR_NONE};
                    n_mode   = IDLE;
                end else if (c < 8'h20) begin
                    job.tail = fail_tail(ERR_CTRL);
                    n_mode   = IDLE;
                end else if (c != CH_BSLASH) begin
                    job.ndata    = 3'd1;
                    job.bytes[0] = c;
                    if (fin) begin
                        job.tail = fail_tail(ERR_UNTERM);
                        n_mode   = IDLE;
                    end
                end else if (fin) begin
                    job.tail = fail_tail(ERR_UNTERM_ESC);
                    n_mode   = IDLE;
                end else begin
                    n_mode = ESC;
                end
            end
            ESC: begin
                if (esc_ok) begin
                    job.ndata    = 3'd1;
                    job.bytes[0] = esc_val;
                    n_mode       = STR;
                    if (fin) begin
                        job.tail = fail_tail(ERR_UNTERM);
                        n_mode   = IDLE;
                    end
                end else if (c == CH_U) begin
                    n_mode = HEX;
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_bad  = 1'b0;
                    n_low  = 1'b0;
                    if (fin) begin
                        job.tail = fail_tail(ERR_TRUNC_U);
                        n_mode   = IDLE;
                    end
                end else begin
                    job.tail = fail_tail(ERR_BAD_ESC);
                    n_mode   = IDLE;
                end
            end
            HEX: begin
                n_acc = acc_next;
                n_bad = r_bad | ~hex_ok;
                if (r_cnt != 2'd3) begin
                    n_cnt = 2'(r_cnt + 2'd1);
                    if (fin) begin
                        job.tail = fail_tail(ERR_TRUNC_U);
                        n_mode   = IDLE;
                    end
                end else begin
                    n_cnt = '0;
                    if (n_bad) begin
                        job.tail = fail_tail(ERR_BAD_U);
                        n_mode   = IDLE;
                    end else if (r_low && (acc_next < 16'hDC00 || acc_next > 16'hDFFF)) begin
                        job.tail = fail_tail(ERR_BAD_LOW);
                        n_mode   = IDLE;
                    end else if (!r_low && acc_next >= 16'hD800 && acc_next <= 16'hDBFF) begin
                        n_high = acc_next[9:0];
                        n_mode = WANT_BS;
                        if (fin) begin
                            job.tail = fail_tail(ERR_LONE_HIGH);
                            n_mode   = IDLE;
                        end
                    end else if (!r_low && acc_next >= 16'hDC00 && acc_next <= 16'hDFFF) begin
                        job.tail = fail_tail(ERR_LONE_LOW);
                        n_mode   = IDLE;
                    end else begin
                        utf8_encode(cp, job.ndata, job.bytes);
                        n_low  = 1'b0;
                        n_mode = STR;
                        if (fin) begin
                            job.tail = fail_tail(ERR_UNTERM);
                            n_mode   = IDLE;
                        end
                    end
                end
            end
            WANT_BS: begin
                if (c != CH_BSLASH || fin) begin
                    job.tail = fail_tail(ERR_LONE_HIGH);
                    n_mode   = IDLE;
                end else begin
                    n_mode = WANT_U;
                end
            end
            WANT_U: begin
                if (c != CH_U) begin
                    job.tail = fail_tail(ERR_LONE_HIGH);
                    n_mode   = IDLE;
                end else begin
                    n_mode = HEX;
                    n_acc  = '0;
                    n_cnt  = '0;
                    n_bad  = 1'b0;
                    n_low  = 1'b1;
                    if (fin) begin
                        job.tail = fail_tail(ERR_TRUNC_U);
                        n_mode   = IDLE;
                    end
                end
            end
            default: begin
                n_mode = IDLE;
                if (c != CH_QUOTE) begin
                    job.tail = fail_tail(ERR_EXPECTED);
                end else begin
                    n_mode = STR;
                    if (fin) begin
                        job.tail = fail_tail(ERR_UNTERM);
                        n_mode   = IDLE;
                    end
                end
            end
        endcase
    end

    assign o_job       = job;
    assign o_job_valid = i_accept && (job.ndata != 3'd0 || job.tail.valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= IDLE;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_bad  <= 1'b0;
            r_high <= '0;
            r_low  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_bad  <= n_bad;
            r_high <= n_high;
            r_low  <= n_low;
        end
    end

endmodule

// ===== rtl/core/jsu_job_fifo.sv =====
// short job queue between front and back end
module jsu_job_fifo
    import jsu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_wdata,
    input  logic i_rd,
    output t_job o_rdata,
    output logic o_empty,
    output logic o_full
);

    t_job              r_mem [JOB_DEPTH];
    logic [JOB_AW-1:0] r_wp, r_rp;
    logic [JOB_AW:0]   r_cnt;

    assign o_rdata = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (JOB_AW+1)'(JOB_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/jsu_back.sv =====
// back end: walks each job one result at a time into the output register
module jsu_back
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_job_empty,
    output logic      o_job_pop,
    output t_out_beat o_beat,
    output logic      o_empty,
    input  logic      i_pop
);

    logic [2:0] r_idx;
    logic       r_valid;
    t_out_beat  r_beat, n_beat;
    logic [2:0] total;
    logic       last;
    logic       load;

    assign total = i_job.ndata + {2'd0, i_job.tail.valid};
    assign last  = (r_idx == 3'(total - 3'd1));
    assign load  = !i_job_empty && (!r_valid || i_pop);

    always_comb begin
        n_beat.run_last = last;
        if (r_idx < i_job.ndata) begin
            n_beat.out_byte   = i_job.bytes[r_idx[1:0]];
            n_beat.kind       = KIND_DATA;
            n_beat.error_code = ERR_NONE;
        end else begin
            n_beat.out_byte   = 8'd0;
            n_beat.kind       = i_job.tail.kind;
            n_beat.error_code = i_job.tail.err;
        end
    end

    assign o_job_pop = load && last;
    assign o_beat    = r_beat;
    assign o_empty   = !r_valid;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 3'd0 : 3'(r_idx + 3'd1);
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/json_string_unescape_utf8.sv =====
// top level of the json string literal unescaper with utf-8 output
//
// input side is a queue write port: a beat (text byte plus final flag) is taken
// at an edge with push high and full low. result side is a queue read port:
// while empty is low the oldest result (byte, kind, error code, run_last) is on
// o_data, and pop at such an edge takes it.
// each input byte yields zero to five results; zero-result bytes (escape prefix,
// hex digits) leave no trace on the output. the front end parses one byte per
// cycle while full is low and hands any results as a job to a four-entry job
// queue; the back end drains one result per cycle into the output register
// while that register is empty or being popped. a byte's results pass through
// the job queue and then the output register before they reach o_data.
// throughput: one byte per cycle while bytes give at most one result each and
// pop is high; a byte with several results holds the back end until each has
// been loaded, and full rises once the job queue is full.
// when the receiver stalls, results wait in the output register and the job
// queue, nothing is dropped. synchronous reset returns the parser to waiting
// for an opening quote and empties both queues.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_beat  i_data,
    output logic      empty,
    input  logic      pop,
    output t_out_beat o_data
);

    logic accept;
    logic job_valid;
    t_job job_in;
    t_job job_out;
    logic job_empty;
    logic job_pop;

    assign accept = push && !full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_beat      (i_data),
        .o_job_valid (job_valid),
        .o_job       (job_in)
    );

    jsu_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_valid),
        .i_wdata (job_in),
        .i_rd    (job_pop),
        .o_rdata (job_out),
        .o_empty (job_empty),
        .o_full  (full)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_beat      (o_data),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

// ===== test/jsu_checker.sv =====
// decoding predictor and result comparator for the json string unescape testbench
`timescale 1ns / 100ps
module jsu_checker
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_beat  i_in,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_beat i_out,
    output int        o_errors,
    output int        o_pending
);

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_STR,
        SCAN_ESC,
        SCAN_HEX,
        SCAN_WANT_BS,
        SCAN_WANT_U
    } t_scan_mode;

    t_scan_mode  scan_mode;
    logic [15:0] hex_acc;
    logic [1:0]  digits_in;
    logic        bad_digit;
    logic [9:0]  high_bits;
    logic        low_escape;

    t_out_beat   beat_results [0:4];
    int          n_results;
    t_out_beat   decoded_beats [$];
    int          mismatches = 0;
    int          results_seen = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("jsu_checker: result %0d: %s", results_seen, msg);
        end
    endtask

    task automatic put_result(input logic [7:0] b, input logic [1:0] k, input logic [3:0] e);
        beat_results[n_results] = {b, k, e, 1'b0};
        n_results++;
    endtask

    task automatic raise_error(input logic [3:0] e);
        put_result(8'h00, KIND_ERROR, e);
        scan_mode = SCAN_IDLE;
    endtask

    task automatic open_hex(input logic low);
        scan_mode  = SCAN_HEX;
        hex_acc    = 16'h0000;
        digits_in  = 2'd0;
        bad_digit  = 1'b0;
        low_escape = low;
    endtask

    task automatic decode_text_byte(input t_in_beat beat);
        logic [7:0]  c;
        logic        fin;
        logic [7:0]  esc_val;
        logic        esc_ok;
        int          d;
        logic [20:0] cp;
        t_out_beat   res;
        int          i;
        c = beat.in_byte;
        fin = beat.final_byte;
        n_results = 0;
        case (scan_mode)
            SCAN_STR: begin
                if (c == 8'h22) begin
                    put_result(8'h00, KIND_DONE, ERR_NONE);
                    scan_mode = SCAN_IDLE;
                end else if (c < 8'h20) begin
                    raise_error(ERR_CTRL);
                end else if (c != 8'h5C) begin
                    put_result(c, KIND_DATA, ERR_NONE);
                    if (fin) raise_error(ERR_UNTERM);
                end else if (fin) begin
                    raise_error(ERR_UNTERM_ESC);
                end else begin
                    scan_mode = SCAN_ESC;
                end
            end
            SCAN_ESC: begin
                esc_ok = 1'b1;
                esc_val = c;
                case (c)
                    8'h22, 8'h5C, "/": esc_val = c;
                    "b": esc_val = 8'h08;
                    "f": esc_val = 8'h0C;
                    "n": esc_val = 8'h0A;
                    "r": esc_val = 8'h0D;
                    "t": esc_val = 8'h09;
                    default: esc_ok = 1'b0;
                endcase
                if (esc_ok) begin
                    put_result(esc_val, KIND_DATA, ERR_NONE);
                    scan_mode = SCAN_STR;
                    if (fin) raise_error(ERR_UNTERM);
                end else if (c == "u") begin
                    open_hex(1'b0);
                    if (fin) raise_error(ERR_TRUNC_U);
                end else begin
                    raise_error(ERR_BAD_ESC);
                end
            end
            SCAN_HEX: begin
                d = -1;
                if (c >= "0" && c <= "9") d = c - "0";
                else if (c >= "a" && c <= "f") d = c - "a" + 10;
                else if (c >= "A" && c <= "F") d = c - "A" + 10;
                hex_acc = hex_acc << 4;
                if (d < 0) bad_digit = 1'b1;
                else hex_acc = hex_acc | 16'(d);
                if (digits_in < 2'd3) begin
                    digits_in = digits_in + 2'd1;
                    if (fin) raise_error(ERR_TRUNC_U);
                end else begin
                    digits_in = 2'd0;
                    if (bad_digit) begin
                        raise_error(ERR_BAD_U);
                    end else if (low_escape && (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF)) begin
                        raise_error(ERR_BAD_LOW);
                    end else if (!low_escape && hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                        high_bits = 10'(hex_acc - 16'hD800);
                        scan_mode = SCAN_WANT_BS;
                        if (fin) raise_error(ERR_LONE_HIGH);
                    end else if (!low_escape && hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                        raise_error(ERR_LONE_LOW);
                    end else begin
                        if (low_escape) begin
                            cp = 21'h10000 + {1'b0, high_bits, 10'd0} + 21'(hex_acc - 16'hDC00);
                        end else begin
                            cp = 21'(hex_acc);
                        end
                        if (cp < 21'h80) begin
                            put_result(cp[7:0], KIND_DATA, ERR_NONE);
                        end else if (cp < 21'h800) begin
                            put_result(8'hC0 | cp[10:6], KIND_DATA, ERR_NONE);
                            put_result(8'h80 | cp[5:0], KIND_DATA, ERR_NONE);
                        end else if (cp < 21'h10000) begin
                            put_result(8'hE0 | cp[15:12], KIND_DATA, ERR_NONE);
                            put_result(8'h80 | cp[11:6], KIND_DATA, ERR_NONE);
                            put_result(8'h80 | cp[5:0], KIND_DATA, ERR_NONE);
                        end else begin
                            put_result(8'hF0 | cp[20:18], KIND_DATA, ERR_NONE);
                            put_result(8'h80 | cp[17:12], KIND_DATA, ERR_NONE);
                            put_result(8'h80 | cp[11:6], KIND_DATA, ERR_NONE);
                            put_result(8'h80 | cp[5:0], KIND_DATA, ERR_NONE);
                        end
                        low_escape = 1'b0;
                        scan_mode = SCAN_STR;
                        if (fin) raise_error(ERR_UNTERM);
                    end
                end
            end
            SCAN_WANT_BS: begin
                if (c != 8'h5C || fin) raise_error(ERR_LONE_HIGH);
                else scan_mode = SCAN_WANT_U;
            end
            SCAN_WANT_U: begin
                if (c != "u") begin
                    raise_error(ERR_LONE_HIGH);
                end else begin
                    open_hex(1'b1);
                    if (fin) raise_error(ERR_TRUNC_U);
                end
            end
            default: begin
                scan_mode = SCAN_IDLE;
                if (c != 8'h22) begin
                    raise_error(ERR_EXPECTED);
                end else begin
                    scan_mode = SCAN_STR;
                    if (fin) raise_error(ERR_UNTERM);
                end
            end
        endcase
        for (i = 0; i < n_results; i++) begin
            res = beat_results[i];
            res.run_last = (i == n_results - 1);
            decoded_beats = {decoded_beats, res};
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            scan_mode  = SCAN_IDLE;
            hex_acc    = 16'h0000;
            digits_in  = 2'd0;
            bad_digit  = 1'b0;
            high_bits  = 10'd0;
            low_escape = 1'b0;
            decoded_beats.delete();
        end else begin
            if (i_push && !i_full) decode_text_byte(i_in);
            if (i_pop && !i_empty) begin
                if (decoded_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat %h", i_out));
                end else begin
                    want = decoded_beats.pop_front();
                    if (i_out.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %h, want %h",
                                                  i_out.out_byte, want.out_byte));
                    if (i_out.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", i_out.kind, want.kind));
                    if (i_out.error_code !== want.error_code)
                        report_mismatch($sformatf("error_code %0d, want %0d",
                                                  i_out.error_code, want.error_code));
                    if (i_out.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  i_out.run_last, want.run_last));
                end
                results_seen++;
            end
        end
        o_pending <= decoded_beats.size();
        o_errors  <= mismatches;
    end

endmodule

// ===== test/tb.sv =====
// top of the json string unescape testbench: clock, reset, string stimulus and verdict
`timescale 1ns / 100ps
module tb;
    import jsu_pkg::*;

    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 190;
    localparam int TAIL_CYCLES    = 20;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_HALF,
        POP_SPARSE,
        POP_PERIODIC
    } t_pop_style;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    t_in_beat  in_beat;
    logic      empty;
    logic      pop;
    t_out_beat out_beat;
    int        hold_count;
    int        errors;
    int        pending;

    logic [7:0] text_q [$];
    int         n_sent = 0;
    int         burst_left = 0;

    json_string_unescape_utf8 dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .push    (push),
        .full    (full),
        .i_data  (in_beat),
        .empty   (empty),
        .pop     (pop),
        .o_data  (out_beat)
    );

    jsu_checker u_check (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_in      (in_beat),
        .i_empty   (empty),
        .i_pop     (pop),
        .i_out     (out_beat),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic add_text(input logic [7:0] b);
        text_q = {text_q, b};
    endtask

    task automatic send_beat(input logic [7:0] b, input logic f);
        int gap;
        if (burst_left == 0) begin
            push <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        push <= 1'b1;
        in_beat <= {b, f};
        @(posedge clk);
        while (full) @(posedge clk);
        burst_left--;
        n_sent++;
    endtask

    task automatic send_str(input string s, input logic fin_last);
        int i;
        for (i = 0; i < s.len(); i++) send_beat(s[i], fin_last && (i == s.len() - 1));
    endtask

    task automatic send_text(input logic fin_last);
        int i;
        for (i = 0; i < text_q.size(); i++) send_beat(text_q[i], fin_last && (i == text_q.size() - 1));
        text_q.delete();
    endtask

    task automatic push_u_escape(input logic [15:0] cp);
        logic [3:0] nib;
        logic [7:0] ch;
        int         i;
        add_text(8'h5C);
        add_text("u");
        for (i = 3; i >= 0; i--) begin
            nib = cp[i*4 +: 4];
            if (nib < 4'd10) ch = 8'h30 + nib;
            else ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
            add_text(ch);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // one literal: mostly well formed with random content, sometimes with a flaw at the end
    task automatic send_literal();
        string       esc_set;
        int          n_el;
        int          k;
        int          pick;
        logic [15:0] cp;
        logic [7:0]  b;
        logic        fin_last;
        esc_set = "\"\\/bfnrt";
        add_text(8'h22);
        fin_last = ($urandom_range(0, 3) == 0);
        n_el = $urandom_range(0, 6);
        for (k = 0; k < n_el; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                b = $urandom_range(8'h20, 8'h7E);
                if (b == 8'h22 || b == 8'h5C) b = 8'h7E;
                add_text(b);
            end else if (pick < 45) begin
                add_text($urandom_range(8'h80, 8'hFF));
            end else if (pick < 62) begin
                add_text(8'h5C);
                add_text(esc_set[$urandom_range(0, 7)]);
            end else if (pick < 80) begin
                case ($urandom_range(0, 2))
                    0: cp = $urandom_range(16'h0000, 16'h007F);
                    1: cp = $urandom_range(16'h0080, 16'h07FF);
                    default: cp = $urandom_range(16'h0800, 16'hFFFF);
                endcase
                if (cp >= 16'hD800 && cp <= 16'hDFFF) cp = cp ^ 16'h4000;
                push_u_escape(cp);
            end else begin
                push_u_escape(16'hD800 + $urandom_range(0, 16'h3FF));
                push_u_escape(16'hDC00 + $urandom_range(0, 16'h3FF));
            end
        end
        if ($urandom_range(0, 99) < 35) begin
            case ($urandom_range(0, 6))
                0: add_text($urandom_range(8'h00, 8'h1F));
                1: begin
                    do b = $urandom_range(0, 255);
                    while (b == 8'h22 || b == 8'h5C || b == "/" || b == "b" || b == "f" ||
                           b == "n" || b == "r" || b == "t" || b == "u");
                    add_text(8'h5C);
                    add_text(b);
                end
                2: begin
                    do b = $urandom_range(0, 255);
                    while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                           (b >= "A" && b <= "F"));
                    push_u_escape($urandom_range(0, 16'hFFFF));
                    text_q[text_q.size() - 1 - $urandom_range(0, 3)] = b;
                end
                3: push_u_escape(16'hDC00 + $urandom_range(0, 16'h3FF));
                4: begin
                    push_u_escape(16'hD800 + $urandom_range(0, 16'h3FF));
                    if ($urandom_range(0, 1)) begin
                        do b = $urandom_range(0, 255); while (b == 8'h5C);
                    end else begin
                        add_text(8'h5C);
                        do b = $urandom_range(0, 255); while (b == "u");
                    end
                    add_text(b);
                end
                5: begin
                    push_u_escape(16'hD800 + $urandom_range(0, 16'h3FF));
                    cp = $urandom_range(0, 16'hFFFF);
                    if (cp >= 16'hDC00 && cp <= 16'hDFFF) cp = cp ^ 16'h4000;
                    push_u_escape(cp);
                end
                default: begin
                    // final byte lands somewhere inside a surrogate pair
                    push_u_escape(16'hD800 + $urandom_range(0, 16'h3FF));
                    push_u_escape(16'hDC00 + $urandom_range(0, 16'h3FF));
                    repeat ($urandom_range(0, 11)) void'(text_q.pop_back());
                    fin_last = 1'b1;
                end
            endcase
        end else begin
            add_text(8'h22);
        end
        send_text(fin_last);
    endtask

    initial begin
        t_pop_style style;
        int         left;
        int         phase;
        int         holds_done;
        pop <= 1'b0;
        style = POP_ALWAYS;
        left = 0;
        phase = 0;
        holds_done = 0;
        forever begin
            @(posedge clk);
            if (hold_count != holds_done) begin
                holds_done++;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                if (left == 0) begin
                    style = t_pop_style'($urandom_range(0, 3));
                    left = $urandom_range(10, 80);
                end
                left--;
                phase++;
                case (style)
                    POP_ALWAYS:   pop <= 1'b1;
                    POP_HALF:     pop <= $urandom_range(0, 1);
                    POP_SPARSE:   pop <= ($urandom_range(0, 4) == 0);
                    POP_PERIODIC: pop <= (phase % 4 == 0);
                    default:      pop <= 1'b1;
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty)) quiet = 0;
            else quiet++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        int  base;
        int  done_random;
        bit  held_first;
        bit  held_second;
        bit  drained_mid;
        rst_n <= 1'b0;
        push <= 1'b0;
        in_beat <= '0;
        hold_count <= 0;
        held_first = 1'b0;
        held_second = 1'b0;
        drained_mid = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat("x", 1'b0);
        send_beat(8'h22, 1'b1);
        send_beat(8'h22, 1'b0);
        send_beat(8'h00, 1'b0);
        send_str("\"\\", 1'b1);
        send_str("\"\\x", 1'b0);
        send_str("\"\\uG", 1'b1);
        send_str("\"a", 1'b0);
        send_beat(8'hFF, 1'b0);
        send_str("\\n\"", 1'b1);
        send_str("\"\\uDE00", 1'b0);
        wait_drained();

        base = n_sent;
        while (n_sent < base + RANDOM_ITEMS) begin
            done_random = n_sent - base;
            if (!held_first && done_random >= 60) begin
                hold_count <= hold_count + 1;
                held_first = 1'b1;
            end
            if (!drained_mid && done_random >= 110) begin
                wait_drained();
                drained_mid = 1'b1;
            end
            if (!held_second && done_random >= 160) begin
                hold_count <= hold_count + 1;
                held_second = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) send_beat($urandom_range(0, 255), $urandom_range(0, 1));
            end
            send_literal();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_job_fifo.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_utf8.sv
test/jsu_checker.sv
test/tb.sv
